// File: hw/rtl/fdtw_pkg.sv
package fdtw_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_W       = 7;
    localparam int SKIP_W        = 30;
    localparam int MAX_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    // structure block token codes
    localparam logic [WORD_W-1:0] CODE_BEGIN_NODE = 32'd1;
    localparam logic [WORD_W-1:0] CODE_END_NODE   = 32'd2;
    localparam logic [WORD_W-1:0] CODE_PROP       = 32'd3;
    localparam logic [WORD_W-1:0] CODE_NOP        = 32'd4;
    localparam logic [WORD_W-1:0] CODE_END        = 32'd9;

    typedef enum logic [2:0] {
        TOK_BEGIN,
        TOK_ENDNODE,
        TOK_PROP,
        TOK_NOP,
        TOK_END,
        TOK_OTHER
    } t_tok;

    typedef enum logic [2:0] {
        PH_TOKEN = 3'd0,
        PH_NAME  = 3'd1,
        PH_PLEN  = 3'd2,
        PH_PNAME = 3'd3,
        PH_VALUE = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_BEGIN   = 3'd0,
        KIND_ENDNODE = 3'd1,
        KIND_PROP    = 3'd2,
        KIND_NOP     = 3'd3,
        KIND_END     = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_UNKNOWN  = 2'd1,
        CAUSE_NOT_ROOT = 2'd2,
        CAUSE_OVERFLOW = 2'd3
    } t_cause;

    typedef struct packed {
        t_tok              tok;
        logic              zero_byte;
        logic              len_zero;
        logic [SKIP_W-1:0] len_words_m1;
    } t_word_class;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
        t_word_class       cls;
    } t_q_entry;

    typedef struct packed {
        t_kind              kind;
        logic [DEPTH_W-1:0] depth;
        logic [WORD_W-1:0]  offset;
        logic [WORD_W-1:0]  plen;
        logic [WORD_W-1:0]  noff;
        t_cause             cause;
    } t_event;

endpackage

// File: hw/rtl/fdtw_front.sv
module fdtw_front (
    input  logic [31:0]           i_word,
    input  logic                  i_start_req,
    output fdtw_pkg::t_q_entry    o_entry
);
    import fdtw_pkg::*;

    t_tok tok;
    logic zero_byte;

    always_comb begin
        unique case (i_word)
            CODE_BEGIN_NODE: tok = TOK_BEGIN;
            CODE_END_NODE:   tok = TOK_ENDNODE;
            CODE_PROP:       tok = TOK_PROP;
            CODE_NOP:        tok = TOK_NOP;
            CODE_END:        tok = TOK_END;
            default:         tok = TOK_OTHER;
        endcase
    end

    // name terminator: any zero byte in the word
    assign zero_byte = (i_word[31:24] == 8'd0) || (i_word[23:16] == 8'd0) ||
                       (i_word[15:8] == 8'd0) || (i_word[7:0] == 8'd0);

    always_comb begin
        o_entry.word          = i_word;
        o_entry.start         = i_start_req;
        o_entry.cls.tok       = tok;
        o_entry.cls.zero_byte = zero_byte;
        // value word count minus one, as if this word were a length
        o_entry.cls.len_zero  = (i_word == '0);
        if (i_word[1:0] != 2'd0) begin
            o_entry.cls.len_words_m1 = i_word[31:2];
        end else begin
            o_entry.cls.len_words_m1 = i_word[31:2] - 30'd1;
        end
    end

endmodule

// File: hw/rtl/fdtw_queue.sv
module fdtw_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fdtw_pkg::t_q_entry    i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output fdtw_pkg::t_q_entry    o_entry
);
    import fdtw_pkg::*;

    t_q_entry              r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_AW-1:0]   n_wr_ptr;
    logic [QUEUE_AW-1:0]   n_rd_ptr;
    logic [QUEUE_CW-1:0]   n_count;
    logic                  do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: hw/rtl/fdtw_back.sv
module fdtw_back #(
    parameter int MAX_DEPTH = fdtw_pkg::MAX_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  fdtw_pkg::t_q_entry    i_q_entry,
    output logic                  o_q_pop,
    input  logic                  i_out_stall,
    output logic                  o_valid,
    output fdtw_pkg::t_event      o_event
);
    import fdtw_pkg::*;

    t_phase             r_phase,  n_phase;
    logic               r_root,   n_root;
    logic [DEPTH_W-1:0] r_depth,  n_depth;
    logic [WORD_W-1:0]  r_pos,    n_pos;
    logic [SKIP_W-1:0]  r_skip,   n_skip;
    logic [WORD_W-1:0]  r_tokoff, n_tokoff;
    logic [WORD_W-1:0]  r_plen,   n_plen;
    logic               r_wzero,  n_wzero;
    logic [SKIP_W-1:0]  r_wm1,    n_wm1;
    logic               r_out_valid;
    t_event             r_event;

    t_phase             e_phase;
    logic               e_root;
    logic [DEPTH_W-1:0] e_depth;
    logic [WORD_W-1:0]  e_pos;
    logic [DEPTH_W-1:0] depth_dec;
    logic               depth_full;
    logic               out_free;
    logic               pop;
    logic               emit;
    t_event             ev;
    t_tok               tok;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = i_q_valid && out_free;
    assign o_q_pop  = pop;
    assign tok      = i_q_entry.cls.tok;

    // start of a new block sees the walk state as after reset
    assign e_phase    = i_q_entry.start ? PH_TOKEN : r_phase;
    assign e_root     = i_q_entry.start ? 1'b0 : r_root;
    assign e_depth    = i_q_entry.start ? '0 : r_depth;
    assign e_pos      = i_q_entry.start ? '0 : r_pos;
    assign depth_dec  = (e_depth != '0) ? e_depth - 1'b1 : e_depth;
    assign depth_full = (e_depth >= DEPTH_W'(MAX_DEPTH));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (pop) begin
            unique case (e_phase)
                PH_TOKEN: begin
                    if (tok == TOK_NOP) begin
                        n_phase = PH_TOKEN;
                    end else if (!e_root && tok != TOK_BEGIN) begin
                        n_phase = PH_DONE;
                    end else begin
                        unique case (tok)
                            TOK_BEGIN:   n_phase = depth_full ? PH_DONE : PH_NAME;
                            TOK_ENDNODE: n_phase = (depth_dec == '0) ? PH_DONE : PH_TOKEN;
                            TOK_PROP:    n_phase = PH_PLEN;
                            default:     n_phase = PH_DONE;
                        endcase
                    end
                end
                PH_NAME:  n_phase = i_q_entry.cls.zero_byte ? PH_TOKEN : PH_NAME;
                PH_PLEN:  n_phase = PH_PNAME;
                PH_PNAME: n_phase = r_wzero ? PH_TOKEN : PH_VALUE;
                PH_VALUE: n_phase = (r_skip == '0) ? PH_TOKEN : PH_VALUE;
                PH_DONE:  n_phase = PH_DONE;
                default:  n_phase = PH_DONE;
            endcase
        end
    end

    // datapath and event
    always_comb begin
        n_root   = r_root;
        n_depth  = r_depth;
        n_pos    = r_pos;
        n_skip   = r_skip;
        n_tokoff = r_tokoff;
        n_plen   = r_plen;
        n_wzero  = r_wzero;
        n_wm1    = r_wm1;
        emit     = 1'b0;
        ev.kind  = KIND_NOP;
        ev.cause = CAUSE_NONE;
        ev.plen  = '0;
        ev.noff  = '0;
        if (pop && e_phase != PH_DONE) begin
            n_root  = e_root;
            n_depth = e_depth;
            n_pos   = e_pos + 32'd4;
        end
        if (pop) begin
            unique case (e_phase)
                PH_TOKEN: begin
                    n_tokoff = e_pos;
                    emit     = (tok != TOK_PROP) || !e_root;
                    if (tok == TOK_NOP) begin
                        ev.kind = KIND_NOP;
                    end else if (!e_root && tok != TOK_BEGIN) begin
                        ev.kind  = KIND_ERROR;
                        ev.cause = CAUSE_NOT_ROOT;
                    end else begin
                        unique case (tok)
                            TOK_BEGIN: begin
                                if (depth_full) begin
                                    ev.kind  = KIND_ERROR;
                                    ev.cause = CAUSE_OVERFLOW;
                                end else begin
                                    ev.kind = KIND_BEGIN;
                                    n_root  = 1'b1;
                                    n_depth = e_depth + 1'b1;
                                end
                            end
                            TOK_ENDNODE: begin
                                ev.kind = KIND_ENDNODE;
                                n_depth = depth_dec;
                            end
                            TOK_PROP: ev.kind = KIND_PROP;
                            TOK_END:  ev.kind = KIND_END;
                            default: begin
                                ev.kind  = KIND_ERROR;
                                ev.cause = CAUSE_UNKNOWN;
                            end
                        endcase
                    end
                end
                PH_NAME: ;
                PH_PLEN: begin
                    n_plen  = i_q_entry.word;
                    n_wzero = i_q_entry.cls.len_zero;
                    n_wm1   = i_q_entry.cls.len_words_m1;
                end
                PH_PNAME: begin
                    emit    = 1'b1;
                    ev.kind = KIND_PROP;
                    ev.plen = r_plen;
                    ev.noff = i_q_entry.word;
                    n_skip  = r_wm1;
                end
                PH_VALUE: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 1'b1;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
        ev.depth  = n_depth;
        ev.offset = (e_phase == PH_TOKEN) ? e_pos : r_tokoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TOKEN;
            r_root      <= 1'b0;
            r_depth     <= '0;
            r_pos       <= '0;
            r_skip      <= '0;
            r_tokoff    <= '0;
            r_plen      <= '0;
            r_wzero     <= 1'b1;
            r_wm1       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_root   <= n_root;
            r_depth  <= n_depth;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_tokoff <= n_tokoff;
            r_plen   <= n_plen;
            r_wzero  <= n_wzero;
            r_wm1    <= n_wm1;
            if (out_free) begin
                r_out_valid <= pop && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit && out_free) begin
            r_event <= ev;
        end
    end

    assign o_valid = r_out_valid;
    assign o_event = r_event;

endmodule

// File: hw/rtl/fdt_structure_token_walker.sv
// Flattened device tree structure block walker. Takes one big-endian 32-bit
// structure word per beat and gives one event per token: begin node, end node,
// property (issued on its name-offset word, with length and name offset), nop,
// end, or error (unknown token, first token not a begin node, or a begin node
// beyond MAX_DEPTH). Node-name and property-value words are consumed without an
// event. start_req on a word restarts the walk at that word; after reset the
// block is ready without it. Once the walk finishes (end token, depth back to
// zero, or error) words are swallowed until the next start_req.
// Rate: one word per clock cycle sustained while the output is not stalled; a
// word's event is held in a queue slot and then in the output register. A decode
// stage feeds a four-entry queue, and the walk engine drains it into a single
// output register, so input stall only rises once the queue is full.
module fdt_structure_token_walker #(
    parameter int MAX_DEPTH = fdtw_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // word channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_word,
    input  logic        i_start_req,
    // event channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_token_kind,
    output logic [6:0]  o_nesting_depth,
    output logic [31:0] o_token_offset,
    output logic [31:0] o_property_length,
    output logic [31:0] o_name_offset,
    output logic [1:0]  o_error_cause
);
    import fdtw_pkg::*;

    t_q_entry front_entry;
    t_q_entry q_entry;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    logic     push;
    t_event   event_out;

    // classify the incoming word
    fdtw_front u_front (
        .i_word      (i_word),
        .i_start_req (i_start_req),
        .o_entry     (front_entry)
    );

    // decouples input beats from output back-pressure
    assign push    = i_valid && !q_full;
    assign o_stall = q_full;

    fdtw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // walk state, depth and offset tracking, event register
    fdtw_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_event     (event_out)
    );

    assign o_token_kind      = event_out.kind;
    assign o_nesting_depth   = event_out.depth;
    assign o_token_offset    = event_out.offset;
    assign o_property_length = event_out.plen;
    assign o_name_offset     = event_out.noff;
    assign o_error_cause     = event_out.cause;

endmodule
